// ===== design/lr_pkg.sv =====
// Shared types and constants for the line rasterizer.
// No dependencies; compiled first.
`default_nettype none

package lr_pkg;

  localparam int unsigned DEF_COORD_BITS  = 10;
  localparam int unsigned FRAME_WIDTH_BITS = 11;
  localparam int unsigned INDEX_BITS       = 20;
  localparam int unsigned COLOR_BITS       = 32;

  localparam logic [FRAME_WIDTH_BITS-1:0] RESET_FRAME_WIDTH = 11'd320;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

endpackage

`default_nettype wire

// ===== design/lr_if.sv =====
// Valid/ready channel interfaces for line commands and emitted pixels.
// Depends on lr_pkg.
`default_nettype none

interface lr_in_if #(
  parameter int unsigned COORD_BITS = lr_pkg::DEF_COORD_BITS
) ();
  import lr_pkg::*;

  logic                  valid;
  logic                  ready;
  op_t                   operation;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [COLOR_BITS-1:0] pixel_color;

  modport source (output valid, operation, start_x, start_y, end_x, end_y, pixel_color,
                  input ready);
  modport sink (input valid, operation, start_x, start_y, end_x, end_y, pixel_color,
                output ready);
endinterface

interface lr_out_if #(
  parameter int unsigned COORD_BITS = lr_pkg::DEF_COORD_BITS
) ();
  import lr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [INDEX_BITS-1:0] word_index;
  logic [COLOR_BITS-1:0] out_color;
  logic                  last_pixel;

  modport source (output valid, out_x, out_y, word_index, out_color, last_pixel,
                  input ready);
  modport sink (input valid, out_x, out_y, word_index, out_color, last_pixel,
                output ready);
endinterface

`default_nettype wire

// ===== design/lr_engine.sv =====
// Bresenham line state and per-item stepping into a pixel register.
// Depends on lr_pkg and lr_in_if.
`default_nettype none

module lr_engine #(
  parameter int unsigned COORD_BITS = lr_pkg::DEF_COORD_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  lr_in_if.sink                              cmd,
  output logic                               pix_valid,
  input  wire logic                          pix_ready,
  output logic [COORD_BITS-1:0]              pix_x,
  output logic [COORD_BITS-1:0]              pix_y,
  output logic [lr_pkg::COLOR_BITS-1:0]      pix_color,
  output logic                               pix_last
);
  import lr_pkg::*;

  localparam int unsigned TW_BITS  = COORD_BITS + 1;
  localparam int unsigned ERR_BITS = COORD_BITS + 3;

  logic [COORD_BITS-1:0]      cur_x, cur_y, target_x, target_y;
  logic [TW_BITS-1:0]         twice_dx, twice_dy;
  logic signed [ERR_BITS-1:0] error_term;
  logic                       step_x_negative, step_y_negative, x_is_major, line_busy;
  logic [COLOR_BITS-1:0]      line_color;

  logic [COORD_BITS-1:0]      cur_x_next, cur_y_next, target_x_next, target_y_next;
  logic [TW_BITS-1:0]         twice_dx_next, twice_dy_next;
  logic signed [ERR_BITS-1:0] error_term_next;
  logic                       step_x_negative_next, step_y_negative_next;
  logic                       x_is_major_next, line_busy_next;
  logic [COLOR_BITS-1:0]      line_color_next;

  logic                       accept, emit, last;
  logic [COORD_BITS-1:0]      abs_dx, abs_dy;
  logic                       dx_neg, dy_neg;
  logic [COORD_BITS-1:0]      x_moved, y_moved;
  logic signed [ERR_BITS-1:0] err_major, err_minor, err_base;

  assign cmd.ready = !pix_valid || pix_ready;
  assign accept    = cmd.valid && cmd.ready;

  assign dx_neg = cmd.end_x < cmd.start_x;
  assign dy_neg = cmd.end_y < cmd.start_y;
  assign abs_dx = dx_neg ? cmd.start_x - cmd.end_x : cmd.end_x - cmd.start_x;
  assign abs_dy = dy_neg ? cmd.start_y - cmd.end_y : cmd.end_y - cmd.start_y;

  assign x_moved = step_x_negative ? cur_x - 1'b1 : cur_x + 1'b1;
  assign y_moved = step_y_negative ? cur_y - 1'b1 : cur_y + 1'b1;

  assign err_major = $signed({2'b00, (x_is_major ? twice_dx : twice_dy)});
  assign err_minor = $signed({2'b00, (x_is_major ? twice_dy : twice_dx)});
  assign err_base  = error_term[ERR_BITS-1] ? error_term : error_term - err_major;

  always_comb begin
    cur_x_next           = cur_x;
    cur_y_next           = cur_y;
    target_x_next        = target_x;
    target_y_next        = target_y;
    twice_dx_next        = twice_dx;
    twice_dy_next        = twice_dy;
    error_term_next      = error_term;
    step_x_negative_next = step_x_negative;
    step_y_negative_next = step_y_negative;
    x_is_major_next      = x_is_major;
    line_color_next      = line_color;
    emit                 = 1'b0;

    case (cmd.operation)
      OP_START: begin
        emit                 = 1'b1;
        cur_x_next           = cmd.start_x;
        cur_y_next           = cmd.start_y;
        target_x_next        = cmd.end_x;
        target_y_next        = cmd.end_y;
        line_color_next      = cmd.pixel_color;
        step_x_negative_next = dx_neg;
        step_y_negative_next = dy_neg;
        twice_dx_next        = {abs_dx, 1'b0};
        twice_dy_next        = {abs_dy, 1'b0};
        x_is_major_next      = abs_dx > abs_dy;
        if (abs_dx > abs_dy) begin
          error_term_next = $signed({2'b00, abs_dy, 1'b0}) - $signed({3'b000, abs_dx});
        end else begin
          error_term_next = $signed({2'b00, abs_dx, 1'b0}) - $signed({3'b000, abs_dy});
        end
      end
      OP_STEP: begin
        if (line_busy) begin
          emit            = 1'b1;
          error_term_next = err_base + err_minor;
          if (x_is_major) begin
            cur_x_next = x_moved;
            if (!error_term[ERR_BITS-1]) begin
              cur_y_next = y_moved;
            end
          end else begin
            cur_y_next = y_moved;
            if (!error_term[ERR_BITS-1]) begin
              cur_x_next = x_moved;
            end
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    last           = x_is_major_next ? (cur_x_next == target_x_next)
                                     : (cur_y_next == target_y_next);
    line_busy_next = emit ? !last : line_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x           <= '0;
      cur_y           <= '0;
      target_x        <= '0;
      target_y        <= '0;
      twice_dx        <= '0;
      twice_dy        <= '0;
      error_term      <= '0;
      step_x_negative <= 1'b0;
      step_y_negative <= 1'b0;
      x_is_major      <= 1'b0;
      line_busy       <= 1'b0;
      line_color      <= '0;
      pix_valid       <= 1'b0;
    end else begin
      if (cmd.ready) begin
        pix_valid <= accept && emit;
      end
      if (accept) begin
        cur_x           <= cur_x_next;
        cur_y           <= cur_y_next;
        target_x        <= target_x_next;
        target_y        <= target_y_next;
        twice_dx        <= twice_dx_next;
        twice_dy        <= twice_dy_next;
        error_term      <= error_term_next;
        step_x_negative <= step_x_negative_next;
        step_y_negative <= step_y_negative_next;
        x_is_major      <= x_is_major_next;
        line_busy       <= line_busy_next;
        line_color      <= line_color_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      pix_x     <= cur_x_next;
      pix_y     <= cur_y_next;
      pix_color <= line_color_next;
      pix_last  <= last;
    end
  end

endmodule

`default_nettype wire

// ===== design/line_rasterizer.sv =====
// Line rasterizer top level: frame width register, stepping engine, index stage.
// Depends on lr_pkg, lr_in_if, lr_out_if and lr_engine.
`default_nettype none

// Bresenham line rasterizer. A start item loads both endpoints and a color and
// yields the first pixel; each step item yields the next pixel of the line, with
// last_pixel set on the far endpoint. A step with no line in progress yields
// nothing. One item is accepted per cycle unless the pixel channel stalls. The
// accepting edge updates the line state and the engine's pixel register; the index
// stage then registers word_index = out_y * frame_width + out_x, formed with one
// multiply-add, and presents the pixel. Backpressure on the pixel channel stalls
// both stages. Write frame_width only while idle.
module line_rasterizer #(
  parameter int unsigned COORD_BITS = lr_pkg::DEF_COORD_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [lr_pkg::FRAME_WIDTH_BITS-1:0] cfg_wdata,
  lr_in_if.sink                                  cmd,
  lr_out_if.source                               pix
);
  import lr_pkg::*;

  localparam int unsigned MUL_BITS = COORD_BITS + FRAME_WIDTH_BITS;
  localparam int unsigned SUM_BITS = (MUL_BITS > INDEX_BITS) ? MUL_BITS : INDEX_BITS;

  logic [FRAME_WIDTH_BITS-1:0] frame_width;

  logic                  eng_valid, eng_ready, eng_last;
  logic [COORD_BITS-1:0] eng_x, eng_y;
  logic [COLOR_BITS-1:0] eng_color;

  logic                  out_valid, out_last;
  logic [COORD_BITS-1:0] out_x, out_y;
  logic [INDEX_BITS-1:0] out_index;
  logic [COLOR_BITS-1:0] out_color;

  logic [SUM_BITS-1:0]   index_sum;

  lr_engine #(
    .COORD_BITS(COORD_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pix_valid (eng_valid),
    .pix_ready (eng_ready),
    .pix_x     (eng_x),
    .pix_y     (eng_y),
    .pix_color (eng_color),
    .pix_last  (eng_last)
  );

  assign eng_ready = !out_valid || pix.ready;
  assign index_sum = SUM_BITS'(eng_y) * SUM_BITS'(frame_width) + SUM_BITS'(eng_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= RESET_FRAME_WIDTH;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_width <= cfg_wdata;
      end
      if (eng_ready) begin
        out_valid <= eng_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eng_valid && eng_ready) begin
      out_x     <= eng_x;
      out_y     <= eng_y;
      out_index <= index_sum[INDEX_BITS-1:0];
      out_color <= eng_color;
      out_last  <= eng_last;
    end
  end

  assign pix.valid      = out_valid;
  assign pix.out_x      = out_x;
  assign pix.out_y      = out_y;
  assign pix.word_index = out_index;
  assign pix.out_color  = out_color;
  assign pix.last_pixel = out_last;

endmodule

`default_nettype wire

// ===== bench/tb_line_rasterizer.sv =====
`timescale 1ns / 100ps
// Testbench for line_rasterizer: directed and random line items checked against an
// in-bench Bresenham predictor, with bursty sender and stalling pixel receiver.
// Depends on lr_pkg, lr_in_if, lr_out_if and the line_rasterizer RTL.

module tb_line_rasterizer;
  import lr_pkg::*;

  localparam int unsigned CB = DEF_COORD_BITS;
  localparam int MAX_COORD = (1 << CB) - 1;
  localparam int RUN_LIMIT_NS = 8_000_000;
  localparam int MAX_REPORTS = 100;
  localparam int LONG_STEPS = 48;

  typedef logic [CB-1:0] coord_t;

  typedef struct packed {
    op_t                   op;
    coord_t                sx;
    coord_t                sy;
    coord_t                ex;
    coord_t                ey;
    logic [COLOR_BITS-1:0] color;
  } line_cmd_t;

  typedef struct packed {
    coord_t                x;
    coord_t                y;
    logic [INDEX_BITS-1:0] index;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_t;

  typedef enum int {
    SINK_OPEN,
    SINK_LIGHT,
    SINK_HEAVY,
    SINK_BLOCKED
  } sink_mode_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we;
  logic [FRAME_WIDTH_BITS-1:0] cfg_wdata;
  logic                        sink_ready = 1'b0;

  lr_in_if  cmd ();
  lr_out_if pix ();

  assign pix.ready = sink_ready;

  line_rasterizer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .pix       (pix)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted line state
  logic [FRAME_WIDTH_BITS-1:0] frame_width_q;
  coord_t                      pos_x, pos_y, goal_x, goal_y;
  logic [CB:0]                 span2_x, span2_y;
  logic signed [CB+2:0]        bres_err;
  logic                        x_back, y_back, x_major, drawing;
  logic [COLOR_BITS-1:0]       ink;

  pixel_t     expected_pixels[$];
  pixel_t     want;
  int         pixels_predicted = 0;
  int         error_count = 0;
  int         burst_left = 0;
  sink_mode_t sink_mode = SINK_OPEN;
  int         sink_left = 0;

  function automatic bit advance_line(input line_cmd_t c, output pixel_t px);
    int          dx, dy, e;
    int unsigned lin;
    bit          at_end;
    if (c.op == OP_START) begin
      pos_x  = c.sx;
      pos_y  = c.sy;
      goal_x = c.ex;
      goal_y = c.ey;
      ink    = c.color;
      dx = int'(goal_x) - int'(pos_x);
      dy = int'(goal_y) - int'(pos_y);
      x_back = dx < 0;
      y_back = dy < 0;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      span2_x = (CB+1)'(2 * dx);
      span2_y = (CB+1)'(2 * dy);
      x_major = dx > dy;
      e = x_major ? 2 * dy - dx : 2 * dx - dy;
      bres_err = (CB+3)'(e);
    end else begin
      if (!drawing) return 1'b0;
      e = bres_err;
      if (x_major) begin
        if (e >= 0) begin
          pos_y = y_back ? pos_y - 1'b1 : pos_y + 1'b1;
          e = e - int'(span2_x);
        end
        pos_x = x_back ? pos_x - 1'b1 : pos_x + 1'b1;
        e = e + int'(span2_y);
      end else begin
        if (e >= 0) begin
          pos_x = x_back ? pos_x - 1'b1 : pos_x + 1'b1;
          e = e - int'(span2_y);
        end
        pos_y = y_back ? pos_y - 1'b1 : pos_y + 1'b1;
        e = e + int'(span2_x);
      end
      bres_err = (CB+3)'(e);
    end
    at_end = x_major ? (pos_x == goal_x) : (pos_y == goal_y);
    drawing = !at_end;
    lin = pos_y;
    lin = lin * frame_width_q + pos_x;
    px.x     = pos_x;
    px.y     = pos_y;
    px.index = lin[INDEX_BITS-1:0];
    px.color = ink;
    px.last  = at_end;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MAX_REPORTS) $display("%0t: mismatch: %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && pix.valid && pix.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel (%0d,%0d) with nothing expected",
                                  pix.out_x, pix.out_y));
      end else begin
        want = expected_pixels.pop_front();
        if (pix.out_x !== want.x)
          report_mismatch($sformatf("out_x got %0d want %0d", pix.out_x, want.x));
        if (pix.out_y !== want.y)
          report_mismatch($sformatf("out_y got %0d want %0d", pix.out_y, want.y));
        if (pix.word_index !== want.index)
          report_mismatch($sformatf("word_index got %0d want %0d", pix.word_index,
                                    want.index));
        if (pix.out_color !== want.color)
          report_mismatch($sformatf("out_color got %h want %h", pix.out_color,
                                    want.color));
        if (pix.last_pixel !== want.last)
          report_mismatch($sformatf("last_pixel got %b want %b", pix.last_pixel,
                                    want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_left = $urandom_range(16, 64);
    end
    sink_left--;
    case (sink_mode)
      SINK_OPEN:  sink_ready <= 1'b1;
      SINK_LIGHT: sink_ready <= $urandom_range(0, 3) != 0;
      SINK_HEAVY: sink_ready <= $urandom_range(0, 3) == 0;
      default:    sink_ready <= 1'b0;
    endcase
  end

  task automatic send_item(input line_cmd_t c);
    pixel_t px;
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        cmd.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
    cmd.valid       <= 1'b1;
    cmd.operation   <= c.op;
    cmd.start_x     <= c.sx;
    cmd.start_y     <= c.sy;
    cmd.end_x       <= c.ex;
    cmd.end_y       <= c.ey;
    cmd.pixel_color <= c.color;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    if (advance_line(c, px)) begin
      expected_pixels.push_back(px);
      pixels_predicted++;
    end
  endtask

  function automatic line_cmd_t random_step();
    line_cmd_t c;
    c = '{OP_STEP, coord_t'($urandom_range(0, MAX_COORD)),
          coord_t'($urandom_range(0, MAX_COORD)), coord_t'($urandom_range(0, MAX_COORD)),
          coord_t'($urandom_range(0, MAX_COORD)), $urandom};
    return c;
  endfunction

  task automatic draw_line(input coord_t sx, input coord_t sy, input coord_t ex,
                           input coord_t ey, input logic [COLOR_BITS-1:0] color,
                           input int steps);
    line_cmd_t c;
    c = '{OP_START, sx, sy, ex, ey, color};
    send_item(c);
    repeat (steps) send_item(random_step());
  endtask

  task automatic wait_idle();
    cmd.valid <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(input logic [FRAME_WIDTH_BITS-1:0] w);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_width_q = w;
  endtask

  function automatic coord_t near_coord(input coord_t c, input int reach);
    int v;
    v = int'(c) - reach + int'($urandom_range(0, 2 * reach));
    if (v < 0) v = 0;
    if (v > MAX_COORD) v = MAX_COORD;
    return v[CB-1:0];
  endfunction

  task automatic random_line();
    coord_t sx, sy, ex, ey;
    int     reach, len, dyl, kind;
    sx = coord_t'($urandom_range(0, MAX_COORD));
    sy = coord_t'($urandom_range(0, MAX_COORD));
    reach = ($urandom_range(0, 39) == 0) ? MAX_COORD : $urandom_range(0, 12);
    ex = near_coord(sx, reach);
    ey = near_coord(sy, reach);
    len = int'(ex) - int'(sx);
    dyl = int'(ey) - int'(sy);
    if (len < 0) len = -len;
    if (dyl < 0) dyl = -dyl;
    if (dyl > len) len = dyl;
    if (len > LONG_STEPS) len = $urandom_range(16, LONG_STEPS);
    kind = $urandom_range(0, 9);
    if (kind == 0) draw_line(sx, sy, ex, ey, $urandom, $urandom_range(0, len));
    else draw_line(sx, sy, ex, ey, $urandom, len);
    if (kind == 9) repeat ($urandom_range(1, 3)) send_item(random_step());
  endtask

  task automatic test_idle_steps();
    send_item(random_step());
    send_item(random_step());
    draw_line(10'd1023, 10'd0, 10'd1023, 10'd0, 32'hFFFF_FFFF, 0);
    send_item(random_step());
  endtask

  task automatic test_octants();
    draw_line(10'd0, 10'd0, 10'd4, 10'd0, 32'h0000_0000, 4);
    draw_line(10'd5, 10'd9, 10'd5, 10'd6, 32'hA5A5_5A5A, 3);
    draw_line(10'd10, 10'd10, 10'd7, 10'd13, $urandom, 3);
    // replace a long line after three pixels
    draw_line(10'd0, 10'd1023, 10'd1023, 10'd0, $urandom, 2);
    draw_line(10'd20, 10'd5, 10'd16, 10'd7, $urandom, 4);
    draw_line(10'd3, 10'd3, 10'd4, 10'd6, $urandom, 3);
  endtask

  task automatic test_index_wrap();
    write_width(11'd1024);
    draw_line(10'd1023, 10'd1023, 10'd1023, 10'd1023, $urandom, 0);
    write_width(11'd2047);
    draw_line(10'd1023, 10'd1023, 10'd1023, 10'd1023, $urandom, 0);
    write_width(11'd0);
    draw_line(10'd1023, 10'd512, 10'd1023, 10'd512, $urandom, 0);
    write_width(11'd1);
    draw_line(10'd0, 10'd1023, 10'd0, 10'd1023, $urandom, 0);
  endtask

  task automatic test_random_lines();
    logic [FRAME_WIDTH_BITS-1:0] widths [6];
    int                          target;
    widths = '{11'd1, 11'd1024, 11'd320, 11'd0, 11'd2047, 11'd1};
    widths[5] = FRAME_WIDTH_BITS'($urandom_range(1, 1024));
    foreach (widths[i]) begin
      write_width(widths[i]);
      target = pixels_predicted + 85;
      while (pixels_predicted < target) random_line();
    end
  endtask

  initial begin
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    cmd.valid       <= 1'b0;
    cmd.operation   <= OP_STEP;
    cmd.start_x     <= '0;
    cmd.start_y     <= '0;
    cmd.end_x       <= '0;
    cmd.end_y       <= '0;
    cmd.pixel_color <= '0;
    frame_width_q = RESET_FRAME_WIDTH;
    pos_x = '0;
    pos_y = '0;
    goal_x = '0;
    goal_y = '0;
    span2_x = '0;
    span2_y = '0;
    bres_err = '0;
    x_back = 1'b0;
    y_back = 1'b0;
    x_major = 1'b0;
    drawing = 1'b0;
    ink = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_idle_steps();
    test_octants();
    test_index_wrap();
    test_random_lines();
    wait_idle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("simulation failed");
    $finish;
  end

endmodule
